// ===== rtl/cbb_pkg.sv =====
// Package with the transaction payload types and register indexes of the clipped bitmap blit.
`default_nettype none
package cbb_pkg;

   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 3;
   localparam int ADDR_W    = 20;
   localparam int BYTE_W    = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_X         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_Y         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_OFFSET  = 3'd6;

   typedef struct packed {
      logic [BYTE_W-1:0] src_byte;
      logic              image_start;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] canvas_address;
      logic [BYTE_W-1:0] color;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/clipped_bitmap_blit.sv =====
// Clipped 8-bit bottom-up bitmap blit: maps source bytes to canvas addresses.
// An accepted request passes through the first-stage register and then the response register.
// Throughput: one request per cycle while req_stall is low; a request that lands off the canvas or on
// padding produces no response and leaves no trace in the response register.
// The position check sits in the first stage, the address multiply in the second.
// Synchronous reset restores the register defaults and clears the source counters.
`default_nettype none
module clipped_bitmap_blit #(
   parameter int MAX_DIM   = 1024,
   parameter int ROW_ALIGN = 4
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire cbb_pkg::req_type                 req_payload,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output cbb_pkg::rsp_type                      rsp_payload,
   input  wire                                   csr_we,
   input  wire [cbb_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire [cbb_pkg::CSR_W-1:0]              csr_wdata
);

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int CNT_W  = $clog2(MAX_DIM + ROW_ALIGN);
   localparam int ROW_W  = $clog2(MAX_DIM);
   localparam int CMP_W  = CNT_W + 2;
   localparam int MAXW_A = (CNT_W > cbb_pkg::CSR_W) ? CNT_W : cbb_pkg::CSR_W;
   localparam int MAXW_B = (MAXW_A > DIM_W) ? MAXW_A : DIM_W;
   localparam int CRD_W  = MAXW_B + 2;
   localparam int PROD_W = (2 * DIM_W + 1 > cbb_pkg::ADDR_W) ? 2 * DIM_W + 1
                                                              : cbb_pkg::ADDR_W;
   localparam int RC_SH  = 16;
   localparam int RECIP  = ((1 << RC_SH) + ROW_ALIGN - 1) / ROW_ALIGN;
   localparam int RV_W   = cbb_pkg::CSR_W + 1;
   localparam int RP_W   = RV_W + RC_SH + 1;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [cbb_pkg::CSR_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic [CNT_W:0] padded_len(input logic [DIM_W-1:0] w);
      logic [RV_W-1:0] v;
      logic [RP_W-1:0] prod;
      v    = RV_W'(w) + RV_W'(ROW_ALIGN - 1);
      prod = RP_W'(v) * RP_W'(RECIP);
      return (CNT_W + 1)'((prod >> RC_SH) * ROW_ALIGN);
   endfunction

   // Configuration registers, widths already clamped where they apply.
   logic [DIM_W-1:0]          cw_ff, ch_ff, iw_ff, ih_ff;
   logic [CNT_W:0]            row_len_ff;
   logic [cbb_pkg::CSR_W-1:0] pos_x_ff, pos_y_ff;
   logic [cbb_pkg::BYTE_W-1:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff      <= clamp_dim(cbb_pkg::CSR_W'(320));
         ch_ff      <= clamp_dim(cbb_pkg::CSR_W'(200));
         iw_ff      <= DIM_W'(1);
         ih_ff      <= DIM_W'(1);
         row_len_ff <= (CNT_W + 1)'(ROW_ALIGN);
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         offset_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            cbb_pkg::CSR_CANVAS_WIDTH:  cw_ff <= clamp_dim(csr_wdata);
            cbb_pkg::CSR_CANVAS_HEIGHT: ch_ff <= clamp_dim(csr_wdata);
            cbb_pkg::CSR_IMAGE_WIDTH: begin
               iw_ff      <= clamp_dim(csr_wdata);
               row_len_ff <= padded_len(clamp_dim(csr_wdata));
            end
            cbb_pkg::CSR_IMAGE_HEIGHT:  ih_ff <= clamp_dim(csr_wdata);
            cbb_pkg::CSR_POS_X:         pos_x_ff <= csr_wdata;
            cbb_pkg::CSR_POS_Y:         pos_y_ff <= csr_wdata;
            cbb_pkg::CSR_COLOR_OFFSET:  offset_ff <= csr_wdata[cbb_pkg::BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake and stage enables.
   logic rsp_valid_ff;
   logic s1_valid_ff;
   logic out_en;
   logic s1_en;
   logic req_fire;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign s1_en     = !s1_valid_ff || out_en;
   assign req_stall = !s1_en;
   assign req_fire  = req_valid && s1_en;

   // Source position counters.
   logic [CNT_W-1:0] col_ff, col_in, col_cur;
   logic [ROW_W-1:0] row_ff, row_in, row_cur;
   logic             pend_ff, pend_in, pend_cur;

   logic [CMP_W-1:0]        col_inc;
   logic [CMP_W-1:0]        row_inc;
   logic                    wrap;
   logic                    last_row;
   logic                    in_image;
   logic [DIM_W-1:0]        rel_row;
   logic [CRD_W-1:0]        x_s, y_s;
   logic                    on_canvas;
   logic                    hit;

   always_comb begin
      col_cur  = req_payload.image_start ? '0 : col_ff;
      row_cur  = req_payload.image_start ? '0 : row_ff;
      pend_cur = req_payload.image_start ? 1'b0 : pend_ff;

      col_inc  = CMP_W'(col_cur) + CMP_W'(1);
      row_inc  = CMP_W'(row_cur) + CMP_W'(1);
      wrap     = col_inc >= CMP_W'(row_len_ff);
      last_row = row_inc >= CMP_W'(ih_ff);

      in_image = (CMP_W'(col_cur) < CMP_W'(iw_ff)) && (CMP_W'(row_cur) < CMP_W'(ih_ff));
      rel_row  = ih_ff - DIM_W'(1) - DIM_W'(row_cur);
      x_s = {{(CRD_W - cbb_pkg::CSR_W){pos_x_ff[cbb_pkg::CSR_W-1]}}, pos_x_ff}
            + CRD_W'(col_cur);
      y_s = {{(CRD_W - cbb_pkg::CSR_W){pos_y_ff[cbb_pkg::CSR_W-1]}}, pos_y_ff}
            + CRD_W'(rel_row);
      on_canvas = !x_s[CRD_W-1] && !y_s[CRD_W-1]
                  && (x_s < CRD_W'(cw_ff)) && (y_s < CRD_W'(ch_ff));
      hit = !pend_cur && in_image && on_canvas;

      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (req_fire) begin
         col_in  = col_cur;
         row_in  = row_cur;
         pend_in = pend_cur;
         if (!pend_cur) begin
            if (wrap) begin
               col_in = '0;
               if (last_row) begin
                  pend_in = 1'b1;
               end else begin
                  row_in = row_inc[ROW_W-1:0];
               end
            end else begin
               col_in = col_inc[CNT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

   // First stage: canvas coordinates of a byte that lands on the canvas.
   logic [DIM_W-1:0]           s1_x_ff, s1_y_ff;
   logic [cbb_pkg::BYTE_W-1:0] s1_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_fire && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_x_ff    <= x_s[DIM_W-1:0];
         s1_y_ff    <= y_s[DIM_W-1:0];
         s1_byte_ff <= req_payload.src_byte;
      end
   end

   // Second stage: address multiply and color offset into the response register.
   logic [PROD_W-1:0] addr_full;
   cbb_pkg::rsp_type  rsp_payload_ff, rsp_payload_in;

   always_comb begin
      addr_full = PROD_W'(s1_y_ff) * PROD_W'(cw_ff) + PROD_W'(s1_x_ff);
      rsp_payload_in.canvas_address = addr_full[cbb_pkg::ADDR_W-1:0];
      rsp_payload_in.color          = s1_byte_ff + offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s1_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Once the whole image has been consumed the column counter rests at zero.
   a_pend_col_zero: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (col_ff == '0))
      else $error("column counter nonzero past the end of the image");

   // A transaction waiting in both stages with the response blocked holds off requests.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("request taken while both stages are blocked");

   // A blocked first stage keeps its transaction.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_en) |=> s1_valid_ff)
      else $error("first stage dropped a blocked transaction");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench that streams bitmap bytes into clipped_bitmap_blit and checks canvas writes.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM      = 1024;
   localparam int ROW_ALIGN    = 4;
   localparam int RANDOM_BYTES = 400;
   localparam int DRAIN_SLACK  = 4;
   localparam int CYCLE_LIMIT  = 200000;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   cbb_pkg::req_type              req_payload = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   cbb_pkg::rsp_type              rsp_payload;
   logic                          csr_we      = 1'b0;
   logic [cbb_pkg::CSR_IDX_W-1:0] csr_index   = '0;
   logic [cbb_pkg::CSR_W-1:0]     csr_wdata   = '0;

   cbb_pkg::req_type pixel_bytes_q[$];
   cbb_pkg::rsp_type canvas_writes_q[$];
   int      queued_bytes   = 0;
   int      accepted_bytes = 0;
   int      checked_writes = 0;
   int      mismatches     = 0;
   int      settings_used  = 0;
   int      idle_pct       = 8;
   int      cycle_count    = 0;

   logic [cbb_pkg::CSR_W-1:0]        cfg_canvas_w     = 11'd320;
   logic [cbb_pkg::CSR_W-1:0]        cfg_canvas_h     = 11'd200;
   logic [cbb_pkg::CSR_W-1:0]        cfg_image_w      = 11'd1;
   logic [cbb_pkg::CSR_W-1:0]        cfg_image_h      = 11'd1;
   logic signed [cbb_pkg::CSR_W-1:0] cfg_pos_x        = '0;
   logic signed [cbb_pkg::CSR_W-1:0] cfg_pos_y        = '0;
   logic [cbb_pkg::BYTE_W-1:0]       cfg_color_offset = '0;
   int                               blit_column      = 0;
   int                               blit_row         = 0;
   bit                               image_done       = 1'b0;

   clipped_bitmap_blit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int effective_dim(logic [cbb_pkg::CSR_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic void blit_byte(cbb_pkg::req_type item);
      int               cw;
      int               ch;
      int               iw;
      int               ih;
      int               row_len;
      int               x;
      int               y;
      cbb_pkg::rsp_type hit;
      cw = effective_dim(cfg_canvas_w);
      ch = effective_dim(cfg_canvas_h);
      iw = effective_dim(cfg_image_w);
      ih = effective_dim(cfg_image_h);
      row_len = ((iw + ROW_ALIGN - 1) / ROW_ALIGN) * ROW_ALIGN;
      if (item.image_start) begin
         blit_column = 0;
         blit_row    = 0;
         image_done  = 1'b0;
      end
      if (image_done) return;
      if (blit_column < iw && blit_row < ih) begin
         x = int'(cfg_pos_x) + blit_column;
         y = int'(cfg_pos_y) + (ih - 1 - blit_row);
         if (x >= 0 && y >= 0 && x < cw && y < ch) begin
            hit.canvas_address = cbb_pkg::ADDR_W'(y * cw + x);
            hit.color          = item.src_byte + cfg_color_offset;
            canvas_writes_q.push_back(hit);
         end
      end
      blit_column++;
      if (blit_column >= row_len) begin
         blit_column = 0;
         if (blit_row + 1 >= ih) image_done = 1'b1;
         else blit_row++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid        <= 1'b0;
         cfg_canvas_w     = 11'd320;
         cfg_canvas_h     = 11'd200;
         cfg_image_w      = 11'd1;
         cfg_image_h      = 11'd1;
         cfg_pos_x        = '0;
         cfg_pos_y        = '0;
         cfg_color_offset = '0;
         blit_column      = 0;
         blit_row         = 0;
         image_done       = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               cbb_pkg::CSR_CANVAS_WIDTH:  cfg_canvas_w     = csr_wdata;
               cbb_pkg::CSR_CANVAS_HEIGHT: cfg_canvas_h     = csr_wdata;
               cbb_pkg::CSR_IMAGE_WIDTH:   cfg_image_w      = csr_wdata;
               cbb_pkg::CSR_IMAGE_HEIGHT:  cfg_image_h      = csr_wdata;
               cbb_pkg::CSR_POS_X:         cfg_pos_x        = csr_wdata;
               cbb_pkg::CSR_POS_Y:         cfg_pos_y        = csr_wdata;
               cbb_pkg::CSR_COLOR_OFFSET:  cfg_color_offset = csr_wdata[cbb_pkg::BYTE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            blit_byte(req_payload);
            accepted_bytes++;
         end
         // A transaction held under stall keeps its payload until accepted.
         if (!(req_valid && req_stall)) begin
            if (pixel_bytes_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_payload <= pixel_bytes_q.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_canvas_writes
      cbb_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (canvas_writes_q.size() == 0) begin
               $display("%0t: unexpected canvas write addr=%0d color=%02h", $time,
                        rsp_payload.canvas_address, rsp_payload.color);
               mismatches++;
            end else begin
               want = canvas_writes_q.pop_front();
               checked_writes++;
               if (rsp_payload.canvas_address !== want.canvas_address) begin
                  $display("%0t: canvas_address expected %0d actual %0d", $time,
                           want.canvas_address, rsp_payload.canvas_address);
                  mismatches++;
               end
               if (rsp_payload.color !== want.color) begin
                  $display("%0t: color expected %02h actual %02h", $time,
                           want.color, rsp_payload.color);
                  mismatches++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d canvas writes outstanding", $time,
                  canvas_writes_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   task automatic queue_byte(logic [cbb_pkg::BYTE_W-1:0] value, logic start);
      cbb_pkg::req_type item;
      item.src_byte    = value;
      item.image_start = start;
      pixel_bytes_q.push_back(item);
      queued_bytes++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (!(accepted_bytes == queued_bytes && canvas_writes_q.size() == 0));
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   task automatic write_reg(logic [cbb_pkg::CSR_IDX_W-1:0] idx,
                            logic [cbb_pkg::CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_all(logic [cbb_pkg::CSR_W-1:0] cw, logic [cbb_pkg::CSR_W-1:0] ch,
                            logic [cbb_pkg::CSR_W-1:0] iw, logic [cbb_pkg::CSR_W-1:0] ih,
                            logic [cbb_pkg::CSR_W-1:0] px, logic [cbb_pkg::CSR_W-1:0] py,
                            logic [cbb_pkg::CSR_W-1:0] co);
      write_reg(cbb_pkg::CSR_CANVAS_WIDTH, cw);
      write_reg(cbb_pkg::CSR_CANVAS_HEIGHT, ch);
      write_reg(cbb_pkg::CSR_IMAGE_WIDTH, iw);
      write_reg(cbb_pkg::CSR_IMAGE_HEIGHT, ih);
      write_reg(cbb_pkg::CSR_POS_X, px);
      write_reg(cbb_pkg::CSR_POS_Y, py);
      write_reg(cbb_pkg::CSR_COLOR_OFFSET, co);
      settings_used++;
   endtask

   function automatic logic [cbb_pkg::CSR_W-1:0] pick_canvas_dim();
      if ($urandom_range(99) < 80) return cbb_pkg::CSR_W'($urandom_range(1, 24));
      case ($urandom_range(3))
         0: return '0;
         1: return 11'd1024;
         2: return 11'd2047;
         default: return cbb_pkg::CSR_W'($urandom_range(2047));
      endcase
   endfunction

   function automatic logic [cbb_pkg::CSR_W-1:0] pick_pos();
      if ($urandom_range(99) < 85) begin
         return cbb_pkg::CSR_W'(int'($urandom_range(0, 30)) - 10);
      end
      return cbb_pkg::CSR_W'($urandom_range(2047));
   endfunction

   initial begin
      int                        phase;
      int                        counted;
      int                        n_images;
      int                        kind;
      int                        total;
      int                        len;
      int                        split_at;
      int                        iw_eff;
      logic [cbb_pkg::CSR_W-1:0] iw;
      logic [cbb_pkg::CSR_W-1:0] ih;
      bit                        with_start;
      bit                        split;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings, no image start: one pixel, padding, then bytes past the image.
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b0);
      queue_byte(8'h56, 1'b0);
      wait_drained();

      // Largest canvas, oversized image width clamps, bottom-right corner and off the right edge.
      write_all(11'd1024, 11'd1024, 11'd2047, 11'd0, 11'd1020, 11'd1023, 11'h7FF);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h00, 1'b0);
      wait_drained();

      // Zero canvas width, tallest image: first row lands on row 0, the next is above the canvas.
      write_all(11'd0, 11'd2047, 11'd1, 11'd1024, 11'd0, 11'h401, 11'd0);
      queue_byte(8'h80, 1'b1);
      queue_byte(8'h11, 1'b0);
      queue_byte(8'h22, 1'b0);
      queue_byte(8'h33, 1'b0);
      queue_byte(8'h44, 1'b0);
      queue_byte(8'h55, 1'b1);
      wait_drained();

      // Most negative and most positive positions, then the position moves mid-image.
      write_all(11'd16, 11'd16, 11'd5, 11'd2, 11'h400, 11'h3FF, 11'd1);
      queue_byte(8'h7F, 1'b1);
      queue_byte(8'h01, 1'b0);
      wait_drained();
      write_reg(cbb_pkg::CSR_POS_X, 11'h7FF);
      write_reg(cbb_pkg::CSR_POS_Y, 11'd0);
      queue_byte(8'hFE, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hAA, 1'b0);
      wait_drained();

      phase   = 0;
      counted = 0;
      while (counted < RANDOM_BYTES) begin
         idle_pct = (phase >= 2 && phase <= 5) ? 0 : 8;
         iw = ($urandom_range(99) < 90) ? cbb_pkg::CSR_W'($urandom_range(1, 13)) :
              cbb_pkg::CSR_W'($urandom_range(0, 20));
         ih = ($urandom_range(99) < 90) ? cbb_pkg::CSR_W'($urandom_range(1, 6)) : '0;
         write_all(pick_canvas_dim(), pick_canvas_dim(), iw, ih, pick_pos(), pick_pos(),
                   cbb_pkg::CSR_W'($urandom_range(2047)));
         iw_eff   = effective_dim(iw);
         total    = ((iw_eff + ROW_ALIGN - 1) / ROW_ALIGN) * ROW_ALIGN * effective_dim(ih);
         n_images = $urandom_range(1, 3);
         for (int img = 0; img < n_images; img++) begin
            kind       = $urandom_range(99);
            with_start = (kind < 94);
            if (kind < 80) len = total;
            else if (kind < 88) len = $urandom_range(1, total);
            else if (kind < 94) len = total + $urandom_range(1, 6);
            else len = $urandom_range(1, 8);
            split    = (len >= 2) && ((phase == 1 && img == 0) || $urandom_range(9) == 0);
            split_at = len / 2;
            for (int i = 0; i < len; i++) begin
               if (split && i == split_at) begin
                  wait_drained();
                  if ($urandom_range(1) == 1) write_reg(cbb_pkg::CSR_POS_X, pick_pos());
               end
               queue_byte(cbb_pkg::BYTE_W'($urandom_range(255)), with_start && i == 0);
               if (with_start && i < total) counted++;
            end
         end
         wait_drained();
         phase++;
      end

      idle_pct = 8;
      wait_drained();
      $display("Summary: %0d pixel bytes over %0d register settings, %0d canvas writes checked",
               accepted_bytes, settings_used, checked_writes);
      $display("Summary: %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
